/* hdl/vdq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Value deque package
// Shared codes, command and status bundles for the value deque block.
// ----------------------------------------------------------------------------
package vdq_pkg;

  // Fixed field widths of the request and response channels.
  localparam int unsigned ActionW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 6;

  // Request action codes.
  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_REMOVE     = 3'd2,
    ACT_LIST_FWD   = 3'd3,
    ACT_LIST_BWD   = 3'd4
  } action_e;

  // Response status codes.
  typedef enum logic [StatusW-1:0] {
    RES_INSERTED  = 3'd0,
    RES_FULL      = 3'd1,
    RES_REMOVED   = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_EMPTY     = 3'd4,
    RES_LISTED    = 3'd5
  } status_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_RM_RD,
    S_RM_CMP,
    S_SH_RD,
    S_SH_WR,
    S_RM_END,
    S_LS_RD,
    S_LS_OUT,
    S_RESULT
  } state_e;

  // Logical position that drives the store address.
  typedef enum logic [1:0] {
    ADDR_POS,
    ADDR_POS_NEXT,
    ADDR_FILL,
    ADDR_FRONT_DEC
  } addr_sel_e;

  // Operations on the walking position counter.
  typedef enum logic [2:0] {
    POS_HOLD,
    POS_ZERO,
    POS_TOP,
    POS_INC,
    POS_DEC
  } pos_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      accept;
    logic      mem_rd;
    logic      mem_wr;
    logic      wr_src_rd;
    addr_sel_e addr_sel;
    logic      front_dec;
    logic      fill_inc;
    logic      fill_dec;
    pos_op_e   pos_op;
    logic      rem_load;
    logic      rem_dec;
    logic      res_load;
    status_e   res_code;
    logic      out_load;
    logic      out_list;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic more;
    logic more2;
    logic rem_one;
    logic out_free;
  } sts_t;

endpackage

/* hdl/vdq_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Value deque request channel
// Valid/ready channel that carries one action and its value.
// ----------------------------------------------------------------------------
interface vdq_req_if;
  import vdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ActionW-1:0]       action;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);

endinterface

/* hdl/vdq_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Value deque response channel
// Valid/ready channel that carries one result of a request.
// ----------------------------------------------------------------------------
interface vdq_rsp_if;
  import vdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [StatusW-1:0]       status;
  logic signed [ValueW-1:0] value_res;
  logic [CountW-1:0]        count;
  logic                     last;

  modport source (output valid, output status, output value_res, output count,
                  output last, input ready);
  modport sink   (input valid, input status, input value_res, input count,
                  input last, output ready);

endinterface

/* hdl/vdq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Value deque controller
// Sequences pushes, the search and close-up of a removal, and list walks.
// ----------------------------------------------------------------------------
module vdq_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [vdq_pkg::ActionW-1:0]  in_action_i,
  output logic                         in_ready_o,
  input  vdq_pkg::sts_t                sts_i,
  output vdq_pkg::cmd_t                cmd_o
);
  import vdq_pkg::*;

  state_e state_q, state_d;
  // Push at the front, or list from the back.
  logic   rev_q, rev_d;

  // State and direction registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rev_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rev_q   <= rev_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_action_i)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: state_d = S_PUSH;
            ACT_REMOVE:   state_d = sts_i.empty ? S_RESULT : S_RM_RD;
            ACT_LIST_FWD, ACT_LIST_BWD: state_d = sts_i.empty ? S_RESULT : S_LS_RD;
            default:      state_d = S_IDLE;
          endcase
        end
      end
      S_PUSH:   state_d = S_RESULT;
      S_RM_RD:  state_d = S_RM_CMP;
      S_RM_CMP: begin
        if (sts_i.match) begin
          state_d = sts_i.more ? S_SH_RD : S_RM_END;
        end else begin
          state_d = sts_i.more ? S_RM_RD : S_RESULT;
        end
      end
      S_SH_RD:  state_d = S_SH_WR;
      S_SH_WR:  state_d = sts_i.more2 ? S_SH_RD : S_RM_END;
      S_RM_END: state_d = S_RESULT;
      S_LS_RD:  state_d = S_LS_OUT;
      S_LS_OUT: begin
        if (sts_i.out_free && sts_i.rem_one) begin
          state_d = S_IDLE;
        end
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    rev_d      = rev_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (in_action_i)
            ACT_PUSH_FRONT: rev_d = 1'b1;
            ACT_PUSH_BACK:  rev_d = 1'b0;
            ACT_REMOVE: begin
              cmd_o.pos_op   = POS_ZERO;
              cmd_o.res_load = sts_i.empty;
              cmd_o.res_code = RES_NOT_FOUND;
            end
            ACT_LIST_FWD, ACT_LIST_BWD: begin
              rev_d          = (in_action_i == ACT_LIST_BWD);
              cmd_o.pos_op   = (in_action_i == ACT_LIST_BWD) ? POS_TOP : POS_ZERO;
              cmd_o.rem_load = 1'b1;
              cmd_o.res_load = sts_i.empty;
              cmd_o.res_code = RES_EMPTY;
            end
            default: cmd_o.accept = 1'b1;
          endcase
        end
      end
      S_PUSH: begin
        cmd_o.res_load = 1'b1;
        if (sts_i.full) begin
          cmd_o.res_code = RES_FULL;
        end else begin
          cmd_o.res_code  = RES_INSERTED;
          cmd_o.mem_wr    = 1'b1;
          cmd_o.addr_sel  = rev_q ? ADDR_FRONT_DEC : ADDR_FILL;
          cmd_o.front_dec = rev_q;
          cmd_o.fill_inc  = 1'b1;
        end
      end
      S_RM_RD: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = ADDR_POS;
      end
      S_RM_CMP: begin
        // Step on to the next entry, or give up at the end of the store.
        if (!sts_i.match) begin
          if (sts_i.more) begin
            cmd_o.pos_op = POS_INC;
          end else begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_code = RES_NOT_FOUND;
          end
        end
      end
      S_SH_RD: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = ADDR_POS_NEXT;
      end
      S_SH_WR: begin
        // Move the later entry one place toward the front.
        cmd_o.mem_wr    = 1'b1;
        cmd_o.wr_src_rd = 1'b1;
        cmd_o.addr_sel  = ADDR_POS;
        cmd_o.pos_op    = POS_INC;
      end
      S_RM_END: begin
        cmd_o.fill_dec = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_code = RES_REMOVED;
      end
      S_LS_RD: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = ADDR_POS;
        cmd_o.pos_op   = rev_q ? POS_DEC : POS_INC;
      end
      S_LS_OUT: begin
        // Hand over one entry and fetch the following one in the same cycle.
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_list = 1'b1;
          cmd_o.rem_dec  = 1'b1;
          if (!sts_i.rem_one) begin
            cmd_o.mem_rd   = 1'b1;
            cmd_o.addr_sel = ADDR_POS;
            cmd_o.pos_op   = rev_q ? POS_DEC : POS_INC;
          end
        end
      end
      S_RESULT: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* hdl/vdq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Value deque datapath
// Circular value store, front and fill registers, walk counters and the
// output register of the response channel.
// ----------------------------------------------------------------------------
module vdq_datapath #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [vdq_pkg::ValueW-1:0]  in_value_i,
  input  vdq_pkg::cmd_t                      cmd_i,
  output vdq_pkg::sts_t                      sts_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [vdq_pkg::StatusW-1:0]        out_status_o,
  output logic signed [vdq_pkg::ValueW-1:0]  out_value_o,
  output logic [vdq_pkg::CountW-1:0]         out_count_o,
  output logic                               out_last_o
);
  import vdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Store and its registered read data.
  logic [VALUE_BITS-1:0] mem_q [DEPTH];
  logic [VALUE_BITS-1:0] rd_q;

  logic [AW-1:0]         front_q, front_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic [CW-1:0]         pos_q, pos_d;
  logic [CW-1:0]         rem_q, rem_d;
  logic [VALUE_BITS-1:0] v_q;
  status_e               res_q;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q;
  logic [ValueW-1:0]     out_value_q;
  logic [CountW-1:0]     out_count_q;
  logic                  out_last_q;

  logic [AW-1:0]         front_dec;
  logic [CW-1:0]         pos_sel;
  logic [AW:0]           slot_sum;
  logic [AW-1:0]         addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  out_free;
  logic [ValueW-1:0]     rd_ext;
  logic [ValueW-1:0]     v_ext;

  // Store address: a logical position offset by the front, wrapped once, or the slot before the front.
  always_comb begin
    front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
    case (cmd_i.addr_sel)
      ADDR_POS:      pos_sel = pos_q;
      ADDR_POS_NEXT: pos_sel = pos_q + CW'(1);
      ADDR_FILL:     pos_sel = fill_q;
      default:       pos_sel = pos_q;
    endcase
    slot_sum = {1'b0, front_q} + (AW + 1)'(pos_sel[AW-1:0]);
    if (slot_sum >= (AW + 1)'(DEPTH)) begin
      slot_sum = slot_sum - (AW + 1)'(DEPTH);
    end
    addr = (cmd_i.addr_sel == ADDR_FRONT_DEC) ? front_dec : slot_sum[AW-1:0];
  end

  assign wr_data = cmd_i.wr_src_rd ? rd_q : v_q;

  // Single-port store with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[addr] <= wr_data;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[addr];
    end
  end

  // Next values of the control registers.
  always_comb begin
    front_d = cmd_i.front_dec ? front_dec : front_q;

    fill_d = fill_q;
    if (cmd_i.fill_inc) begin
      fill_d = fill_q + CW'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = fill_q - CW'(1);
    end

    case (cmd_i.pos_op)
      POS_HOLD: pos_d = pos_q;
      POS_ZERO: pos_d = '0;
      POS_TOP:  pos_d = fill_q - CW'(1);
      POS_INC:  pos_d = pos_q + CW'(1);
      POS_DEC:  pos_d = pos_q - CW'(1);
      default:  pos_d = pos_q;
    endcase

    rem_d = rem_q;
    if (cmd_i.rem_load) begin
      rem_d = fill_q;
    end else if (cmd_i.rem_dec) begin
      rem_d = rem_q - CW'(1);
    end
  end

  // Output register frees up when its result is taken.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stored values are sign-extended or cut to the channel width.
  assign rd_ext = ValueW'(signed'(rd_q));
  assign v_ext  = ValueW'(signed'(v_q));

  // Request value, result code and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      v_q <= VALUE_BITS'(in_value_i);
    end
    if (cmd_i.res_load) begin
      res_q <= cmd_i.res_code;
    end
    if (cmd_i.out_load) begin
      out_count_q <= CountW'(fill_q);
      if (cmd_i.out_list) begin
        out_status_q <= RES_LISTED;
        out_value_q  <= rd_ext;
        out_last_q   <= (rem_q == CW'(1));
      end else begin
        out_status_q <= res_q;
        out_value_q  <= (res_q == RES_EMPTY) ? '0 : v_ext;
        out_last_q   <= 1'b1;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.full     = (fill_q == CW'(DEPTH));
    sts_o.empty    = (fill_q == '0);
    sts_o.match    = (rd_q == v_q);
    sts_o.more     = ((CW + 1)'(pos_q) + (CW + 1)'(1)) < (CW + 1)'(fill_q);
    sts_o.more2    = ((CW + 1)'(pos_q) + (CW + 1)'(2)) < (CW + 1)'(fill_q);
    sts_o.rem_one  = (rem_q == CW'(1));
    sts_o.out_free = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_count_o  = out_count_q;
  assign out_last_o   = out_last_q;

endmodule

/* hdl/value_deque_with_remove_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Value deque with remove
// Bounded ordered sequence of signed values with push front, push back,
// remove first match and list in either direction.
// ----------------------------------------------------------------------------
// The block takes one request at a time and holds up to DEPTH values in a
// single-port circular store, one read or one write per cycle. A push passes
// through a push state and then a result state, which loads its result into
// the output register. A removal reads and compares one entry after another
// from the front and then closes the gap, reading and writing each later entry
// in turn. A list delivers one entry per cycle after a read state while the
// response side keeps up. The next request is taken as soon as the last
// result of the previous one sits in the output register, even if it has not
// been taken yet. Action codes five to seven are accepted and ignored.
module value_deque_with_remove_top #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vdq_req_if.sink   req,
  vdq_rsp_if.source rsp
);
  import vdq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller.
  vdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_action_i (req.action),
    .in_ready_o  (req.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath with the store and the output register.
  vdq_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_value_i   (req.value),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (rsp.ready),
    .out_valid_o  (rsp.valid),
    .out_status_o (rsp.status),
    .out_value_o  (rsp.value_res),
    .out_count_o  (rsp.count),
    .out_last_o   (rsp.last)
  );

endmodule
